/* src/dds_pkg.sv */
// ----------------------------------------------------------------------------
// Dense shortest-path engine package
// Sizes, operation codes and memory entry layouts that the engine and its RAM use.
// ----------------------------------------------------------------------------
package dds_pkg;

	localparam int MAX_VERTICES   = 64;
	localparam int VIDX_BITS      = 6;
	localparam int VCNT_BITS      = 7;
	localparam int WEIGHT_BITS    = 10;
	localparam int DIST_BITS      = 16;
	localparam int EDGE_ADDR_BITS = 2 * VIDX_BITS;
	localparam int PRED_BITS      = 7;

	localparam logic [PRED_BITS-1:0] NO_PRED = 7'h7F;
	localparam logic [VCNT_BITS-1:0] VCOUNT_RESET = 7'd64;

	// Register index of vertex_count on the configuration port.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_RUN      = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		logic                   present;
		logic [WEIGHT_BITS-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] path_len;
		logic                 known;
		logic                 visited;
		logic [PRED_BITS-1:0] prev;
	} vertex_t;

endpackage

/* src/dense_dijkstra_shortest_paths.sv */
// ----------------------------------------------------------------------------
// Dense Dijkstra shortest-path engine
// Weighted undirected graph held in a vertex-by-vertex weight RAM, solved
// with the array form of Dijkstra's algorithm.
// ----------------------------------------------------------------------------
// Usage:
// Input beats on the s_ stream carry an operation in s_tuser: add edge, run
// from a source, or clear the graph. An edge naming a vertex outside the
// active range is dropped. A clear sweeps the 4096-entry edge RAM,
// one entry per cycle.
// A run first initialises every vertex entry, then makes n-1 rounds, each a
// set-up step, a scan of the vertex RAM and a mark step, plus, for a reached
// vertex, a relaxation pass over its adjacency row.
// Results then leave on the m_ stream, one beat per vertex in index order,
// with m_tlast on the last vertex, each read once the one before is taken.
// A stalled receiver simply holds the result beat; the engine waits.
// Only one item is in progress at a time; s_tready is high only when idle.
// After reset the edge RAM is cleared before s_tready rises;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module dense_dijkstra_shortest_paths (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: first_vertex[5:0], second_vertex[11:6], edge_weight[21:12],
	// source_vertex[27:22], zero[31:28]
	input  logic [31:0] s_tdata,
	// s_tuser: operation[1:0]
	input  logic [1:0]  s_tuser,
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: vertex_index[5:0], distance[21:6], predecessor[27:22],
	// has_predecessor[28], reachable[29], zero[31:30]
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	import dds_pkg::*;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_ADD_RD, ST_ADD_CMP, ST_ADD_WR2, ST_INIT, ST_ROUND,
		ST_SCAN, ST_MARK, ST_RELAX, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
	} state_t;

	state_t                      state_q;
	logic [VCNT_BITS-1:0]        vcount_q;
	logic [VCNT_BITS-1:0]        n_eff;
	logic [EDGE_ADDR_BITS-1:0]   clr_q;
	logic [VIDX_BITS-1:0]        a_q, b_q, src_q;
	logic [WEIGHT_BITS-1:0]      w_q;
	logic [VCNT_BITS-1:0]        cnt_q;
	logic [VCNT_BITS-1:0]        round_q;
	logic                        v_s1;
	logic [VIDX_BITS-1:0]        idx_s1;
	logic                        found_q;
	logic [VIDX_BITS-1:0]        best_q;
	logic [DIST_BITS-1:0]        best_dist_q;
	logic                        best_known_q;
	logic [PRED_BITS-1:0]        best_prev_q;
	logic                        m_tvalid_q;
	logic [31:0]                 m_tdata_q;
	logic                        m_tlast_q;

	logic                        eram_we;
	logic [EDGE_ADDR_BITS-1:0]   eram_waddr, eram_raddr;
	edge_t                       eram_wdata, eram_rdata;
	logic                        vram_we;
	logic [VIDX_BITS-1:0]        vram_waddr;
	vertex_t                     vram_wdata, vram_rdata;

	logic                        cfg_wr;
	logic [VIDX_BITS-1:0]        in_a, in_b;
	logic                        add_upd;
	logic [DIST_BITS:0]          sum;
	logic [DIST_BITS-1:0]        cand;
	logic                        rl_upd;
	logic                        scan_take;

	// A count of zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = VCNT_BITS'(1);
		end else if (vcount_q > VCNT_BITS'(MAX_VERTICES)) begin
			n_eff = VCNT_BITS'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q;
		end
	end

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign prdata  = (paddr[2] == REG_VERTEX_COUNT) ? {25'd0, vcount_q} : 32'd0;

	assign in_a = s_tdata[5:0];
	assign in_b = s_tdata[11:6];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign add_upd = !eram_rdata.present || (w_q < eram_rdata.weight);

	assign sum  = {1'b0, best_dist_q} + {{(DIST_BITS + 1 - WEIGHT_BITS){1'b0}}, eram_rdata.weight};
	assign cand = sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
	assign rl_upd = (state_q == ST_RELAX) && v_s1 && !vram_rdata.visited &&
		eram_rdata.present && (!vram_rdata.known || (cand < vram_rdata.path_len));

	// First unvisited vertex is taken; later ones only if reached and either closer or the pick so far is unreached.
	assign scan_take = v_s1 && !vram_rdata.visited && (!found_q ||
		(vram_rdata.known && (!best_known_q || (vram_rdata.path_len < best_dist_q))));

	always_comb begin
		eram_we    = 1'b0;
		eram_waddr = clr_q;
		eram_wdata = '0;
		eram_raddr = {best_q, cnt_q[VIDX_BITS-1:0]};
		case (state_q)
			ST_CLR: begin
				eram_we = 1'b1;
			end
			ST_ADD_RD: begin
				eram_raddr = {a_q, b_q};
			end
			ST_ADD_CMP: begin
				eram_we    = add_upd;
				eram_waddr = {a_q, b_q};
				eram_wdata = '{present: 1'b1, weight: w_q};
			end
			ST_ADD_WR2: begin
				eram_we    = 1'b1;
				eram_waddr = {b_q, a_q};
				eram_wdata = '{present: 1'b1, weight: w_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		vram_we    = 1'b0;
		vram_waddr = cnt_q[VIDX_BITS-1:0];
		vram_wdata = '{path_len: '0, known: (cnt_q[VIDX_BITS-1:0] == src_q),
			visited: 1'b0, prev: NO_PRED};
		case (state_q)
			ST_INIT: begin
				vram_we = 1'b1;
			end
			ST_MARK: begin
				vram_we    = 1'b1;
				vram_waddr = best_q;
				vram_wdata = '{path_len: best_dist_q, known: best_known_q,
					visited: 1'b1, prev: best_prev_q};
			end
			ST_RELAX: begin
				vram_we    = rl_upd;
				vram_waddr = idx_s1;
				vram_wdata = '{path_len: cand, known: 1'b1, visited: 1'b0,
					prev: {1'b0, best_q}};
			end
			default: begin
			end
		endcase
	end

	dds_ram #(.ADDR_BITS(EDGE_ADDR_BITS), .DATA_BITS($bits(edge_t))) u_edge_ram (
		.clk   (clk),
		.we    (eram_we),
		.waddr (eram_waddr),
		.wdata (eram_wdata),
		.raddr (eram_raddr),
		.rdata (eram_rdata)
	);

	dds_ram #(.ADDR_BITS(VIDX_BITS), .DATA_BITS($bits(vertex_t))) u_vertex_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vram_waddr),
		.wdata (vram_wdata),
		.raddr (cnt_q[VIDX_BITS-1:0]),
		.rdata (vram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= VCOUNT_RESET;
			state_q    <= ST_CLR;
			clr_q      <= '0;
			cnt_q      <= '0;
			round_q    <= '0;
			v_s1       <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_VERTEX_COUNT)) begin
				vcount_q <= pwdata[VCNT_BITS-1:0];
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {EDGE_ADDR_BITS{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						a_q   <= in_a;
						b_q   <= in_b;
						w_q   <= s_tdata[21:12];
						src_q <= s_tdata[27:22];
						cnt_q <= '0;
						case (op_t'(s_tuser))
							OP_ADD_EDGE: begin
								if ({1'b0, in_a} < n_eff && {1'b0, in_b} < n_eff) begin
									state_q <= ST_ADD_RD;
								end
							end
							OP_RUN: begin
								round_q <= '0;
								state_q <= ST_INIT;
							end
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_CMP;
				end
				ST_ADD_CMP: begin
					state_q <= add_upd ? ST_ADD_WR2 : ST_IDLE;
				end
				ST_ADD_WR2: begin
					state_q <= ST_IDLE;
				end
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_eff - 1'b1) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					cnt_q   <= '0;
					v_s1    <= 1'b0;
					found_q <= 1'b0;
					if ({1'b0, round_q} + 8'd1 < {1'b0, n_eff}) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_OUT_RD;
					end
				end
				ST_SCAN: begin
					if (cnt_q < n_eff) begin
						cnt_q <= cnt_q + 1'b1;
					end
					v_s1   <= (cnt_q < n_eff);
					idx_s1 <= cnt_q[VIDX_BITS-1:0];
					if (scan_take) begin
						found_q      <= 1'b1;
						best_q       <= idx_s1;
						best_dist_q  <= vram_rdata.path_len;
						best_known_q <= vram_rdata.known;
						best_prev_q  <= vram_rdata.prev;
					end
					if (cnt_q == n_eff && !v_s1) begin
						cnt_q   <= '0;
						state_q <= found_q ? ST_MARK : ST_OUT_RD;
					end
				end
				ST_MARK: begin
					round_q <= round_q + 1'b1;
					v_s1    <= 1'b0;
					state_q <= best_known_q ? ST_RELAX : ST_ROUND;
				end
				ST_RELAX: begin
					if (cnt_q < n_eff) begin
						cnt_q <= cnt_q + 1'b1;
					end
					v_s1   <= (cnt_q < n_eff);
					idx_s1 <= cnt_q[VIDX_BITS-1:0];
					if (cnt_q == n_eff && !v_s1) begin
						state_q <= ST_ROUND;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					m_tdata_q <= {2'b00, vram_rdata.known,
						(vram_rdata.prev != NO_PRED),
						(vram_rdata.prev != NO_PRED) ? vram_rdata.prev[VIDX_BITS-1:0] :
							{VIDX_BITS{1'b0}},
						vram_rdata.known ? vram_rdata.path_len : {DIST_BITS{1'b0}},
						cnt_q[VIDX_BITS-1:0]};
					m_tlast_q  <= (cnt_q == n_eff - 1'b1);
					m_tvalid_q <= 1'b1;
					state_q    <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// A result beat is only ever shown while the engine waits for it to go.
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == ST_OUT_WAIT))
		else $error("result beat outside output wait");

	// No input is taken while a result is still pending.
	a_in_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while result pending");

	// Relaxation only writes vertices inside the active range.
	a_relax_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vram_we && (state_q == ST_RELAX)) |-> ({1'b0, vram_waddr} < n_eff))
		else $error("relaxation wrote outside the active vertices");

	// After the clearing pass ends the engine is idle.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR && clr_q == {EDGE_ADDR_BITS{1'b1}}) |=> s_tready)
		else $error("clearing pass did not return to idle");
`endif

endmodule

/* src/dds_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dds_ram #(
	parameter int ADDR_BITS = 6,
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem_q [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* tb/sv/dense_dijkstra_shortest_paths_tb.sv */
// ----------------------------------------------------------------------------
// Dense Dijkstra shortest-path engine testbench
// Loads graphs edge by edge, clears them and runs shortest-path searches
// under several vertex counts. A predictor in the bench computes each run's
// per-vertex results, and the monitor checks every output beat against them.
// ----------------------------------------------------------------------------
module dense_dijkstra_shortest_paths_tb;
	import dds_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int IDLE_PCT    = 31;
	localparam int SETTLE      = 4400;

	typedef struct {
		op_t        op;
		logic [5:0] va;
		logic [5:0] vb;
		logic [9:0] wt;
		logic [5:0] src;
	} graph_cmd_t;

	typedef struct {
		logic [5:0]  idx;
		logic [15:0] path_len;
		logic [5:0]  pred;
		logic        has_pred;
		logic        reach;
		logic        last;
	} vertex_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	graph_cmd_t     cmd_q[$];
	vertex_result_t path_q[$];
	int             errors;
	int             cycles;
	bit             calm;
	bit             hold_req;
	bit             hold_done;
	int             hold_left;

	// Bench copy of the engine's graph and configuration.
	logic [9:0] wt_store[MAX_VERTICES*MAX_VERTICES];
	bit         edge_on[MAX_VERTICES*MAX_VERTICES];
	int         vcount;

	dense_dijkstra_shortest_paths dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int live_count();
		if (vcount == 0)
			return 1;
		if (vcount > MAX_VERTICES)
			return MAX_VERTICES;
		return vcount;
	endfunction

	// Applies one accepted command to the bench graph; a run queues its results.
	function automatic void apply_graph_cmd(logic [1:0] opc, logic [31:0] d);
		int             n, a, b, w, s, best, v, r, cand, ab, ba, idx;
		logic [15:0]    path_len[MAX_VERTICES];
		bit             known[MAX_VERTICES];
		bit             seen[MAX_VERTICES];
		int             prev[MAX_VERTICES];
		vertex_result_t rec;
		n = live_count();
		a = d[5:0];
		b = d[11:6];
		w = d[21:12];
		s = d[27:22];
		case (op_t'(opc))
			OP_ADD_EDGE: begin
				if (a < n && b < n) begin
					ab = a * MAX_VERTICES + b;
					ba = b * MAX_VERTICES + a;
					if (!edge_on[ab] || w < wt_store[ab]) begin
						wt_store[ab] = 10'(w);
						wt_store[ba] = 10'(w);
						edge_on[ab] = 1;
						edge_on[ba] = 1;
					end
				end
			end
			OP_CLEAR: begin
				foreach (edge_on[k])
					edge_on[k] = 0;
			end
			OP_RUN: begin
				for (v = 0; v < n; v++) begin
					path_len[v] = '0;
					known[v] = 0;
					seen[v] = 0;
					prev[v] = -1;
				end
				if (s < n)
					known[s] = 1;
				for (r = 0; r + 1 < n; r++) begin
					best = n;
					for (v = 0; v < n; v++) begin
						if (seen[v])
							continue;
						if (best == n)
							best = v;
						else if (known[v] && (!known[best] || path_len[v] < path_len[best]))
							best = v;
					end
					if (best >= n)
						break;
					seen[best] = 1;
					if (!known[best])
						continue;
					for (v = 0; v < n; v++) begin
						idx = best * MAX_VERTICES + v;
						if (seen[v] || !edge_on[idx])
							continue;
						cand = int'(path_len[best]) + int'(wt_store[idx]);
						if (cand > 65535)
							cand = 65535;
						if (!known[v] || cand < path_len[v]) begin
							path_len[v] = 16'(cand);
							known[v] = 1;
							prev[v] = best;
						end
					end
				end
				for (v = 0; v < n; v++) begin
					rec.idx = 6'(v);
					rec.path_len = known[v] ? path_len[v] : 16'd0;
					rec.has_pred = prev[v] >= 0;
					rec.pred = prev[v] >= 0 ? 6'(prev[v]) : 6'd0;
					rec.reach = known[v];
					rec.last = v + 1 == n;
					path_q.push_back(rec);
				end
			end
			default: ;
		endcase
	endfunction

	// Driver: presents queued commands, idling at random unless calm is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			graph_cmd_t c;
			if (s_tvalid && s_tready)
				apply_graph_cmd(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					c = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= c.op;
					s_tdata <= {4'd0, c.src, c.wt, c.vb, c.va};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat; holds off at random and once for long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			vertex_result_t e;
			if (m_tvalid && m_tready) begin
				if (path_q.size() == 0) begin
					$display("%0t: unexpected result beat %h last %b", $realtime, m_tdata, m_tlast);
					errors++;
				end else begin
					e = path_q.pop_front();
					if (m_tdata[5:0] !== e.idx) begin
						$display("%0t: vertex_index expected %0d actual %0d", $realtime, e.idx, m_tdata[5:0]);
						errors++;
					end
					if (m_tdata[21:6] !== e.path_len) begin
						$display("%0t: distance expected %0d actual %0d", $realtime, e.path_len, m_tdata[21:6]);
						errors++;
					end
					if (m_tdata[27:22] !== e.pred) begin
						$display("%0t: predecessor expected %0d actual %0d", $realtime, e.pred, m_tdata[27:22]);
						errors++;
					end
					if (m_tdata[28] !== e.has_pred) begin
						$display("%0t: has_predecessor expected %b actual %b", $realtime, e.has_pred, m_tdata[28]);
						errors++;
					end
					if (m_tdata[29] !== e.reach) begin
						$display("%0t: reachable expected %b actual %b", $realtime, e.reach, m_tdata[29]);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$display("%0t: last expected %b actual %b", $realtime, e.last, m_tlast);
						errors++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 3000;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dense_dijkstra_shortest_paths regression: fail");
			$finish;
		end
	end

	task automatic push_cmd(op_t op, int a, int b, int w, int s);
		graph_cmd_t c;
		c.op = op;
		c.va = 6'(a);
		c.vb = 6'(b);
		c.wt = 10'(w);
		c.src = 6'(s);
		cmd_q.push_back(c);
	endtask

	task automatic set_vertex_count(int value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd4 * REG_VERTEX_COUNT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		vcount = value & 'h7F;
	endtask

	// Waits until every command is taken and every result has arrived, then
	// lets a trailing clear or add finish inside the engine.
	task automatic drain();
		while (cmd_q.size() > 0 || s_tvalid || path_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// A random batch: at times a clear, then mostly edges inside the live range, some stray ones, runs and no-ops.
	task automatic random_batch(int count);
		int n, k, pick;
		n = live_count();
		if ($urandom_range(99) < 20)
			push_cmd(OP_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(1023), 0);
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				push_cmd(OP_ADD_EDGE, $urandom_range(n - 1), $urandom_range(n - 1),
					$urandom_range(1023), $urandom_range(63));
			else if (pick < 65)
				push_cmd(OP_ADD_EDGE, $urandom_range(63), $urandom_range(63),
					$urandom_range(1023), $urandom_range(63));
			else if (pick < 70)
				push_cmd(OP_NONE, $urandom_range(63), $urandom_range(63),
					$urandom_range(1023), $urandom_range(63));
			else if (pick < 92)
				push_cmd(OP_RUN, $urandom_range(63), $urandom_range(63),
					$urandom_range(1023), $urandom_range(n - 1));
			else
				push_cmd(OP_RUN, $urandom_range(63), $urandom_range(63),
					$urandom_range(1023), $urandom_range(63));
		end
		push_cmd(OP_RUN, 0, 0, 0, $urandom_range(n - 1));
	endtask

	initial begin
		int p;
		errors = 0;
		cycles = 0;
		calm = 0;
		hold_req = 0;
		vcount = VCOUNT_RESET;
		foreach (edge_on[k])
			edge_on[k] = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Full size: extreme weights, a parallel edge, a self loop, op code 3.
		set_vertex_count(64);
		push_cmd(OP_ADD_EDGE, 0, 63, 1023, 0);
		push_cmd(OP_ADD_EDGE, 63, 0, 5, 0);
		push_cmd(OP_ADD_EDGE, 63, 0, 900, 0);
		push_cmd(OP_ADD_EDGE, 62, 62, 0, 0);
		push_cmd(OP_ADD_EDGE, 0, 1, 0, 0);
		push_cmd(OP_ADD_EDGE, 62, 63, 1023, 0);
		push_cmd(OP_NONE, 63, 63, 1023, 63);
		push_cmd(OP_RUN, 0, 0, 0, 0);
		push_cmd(OP_RUN, 0, 0, 0, 63);
		push_cmd(OP_CLEAR, 0, 0, 0, 0);
		push_cmd(OP_RUN, 0, 0, 0, 5);
		drain();

		// A count of zero acts as one vertex; the source may lie outside.
		set_vertex_count(0);
		push_cmd(OP_ADD_EDGE, 0, 1, 7, 0);
		push_cmd(OP_ADD_EDGE, 0, 0, 3, 0);
		push_cmd(OP_RUN, 0, 0, 0, 0);
		push_cmd(OP_RUN, 0, 0, 0, 5);
		drain();

		// Oversized count acts as the maximum.
		set_vertex_count(127);
		push_cmd(OP_ADD_EDGE, 10, 20, 1, 0);
		push_cmd(OP_RUN, 0, 0, 0, 20);
		drain();

		// Load at eight vertices, then lower the count so stale edges drop out.
		set_vertex_count(8);
		push_cmd(OP_ADD_EDGE, 1, 6, 2, 0);
		push_cmd(OP_ADD_EDGE, 6, 2, 3, 0);
		push_cmd(OP_ADD_EDGE, 1, 2, 9, 0);
		push_cmd(OP_ADD_EDGE, 3, 9, 4, 0);
		push_cmd(OP_RUN, 0, 0, 0, 1);
		push_cmd(OP_RUN, 0, 0, 0, 10);
		drain();
		set_vertex_count(4);
		push_cmd(OP_RUN, 0, 0, 0, 1);
		drain();

		for (p = 0; p < 9; p++) begin
			if (p == 6)
				set_vertex_count(40);
			else if (p == 7)
				set_vertex_count(1);
			else
				set_vertex_count($urandom_range(2, 12));
			calm = p == 3 || p == 4;
			// The long receiver stall lands while further commands are still queued.
			if (p == 1)
				hold_req = 1;
			random_batch(p == 6 ? 3 : 8);
			drain();
		end

		if (errors == 0)
			$display("dense_dijkstra_shortest_paths regression: pass");
		else
			$display("dense_dijkstra_shortest_paths regression: fail");
		$finish;
	end

endmodule
